[hdl/quicksort_median_of_three_defines.svh]
// assertion macros for the quicksort block checkers
`ifndef QUICKSORT_MEDIAN_OF_THREE_DEFINES_SVH
`define QUICKSORT_MEDIAN_OF_THREE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define QSM3_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define QSM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/qsm3_pkg.sv]
// shared constants, sequencer codes and control structs of the quicksort block
`default_nettype none

package qsm3_pkg;

    localparam int MAX_ELEMS_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int POS_W          = 6;
    localparam int CMP_W          = 11;
    localparam logic [CMP_W-1:0] CMP_MAX = '1;

    // sequencer codes, shared by controller state and datapath operation
    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] S_INIT  = 5'd1;
    localparam logic [ST_W-1:0] S_POP   = 5'd2;
    localparam logic [ST_W-1:0] S_RANGE = 5'd3;
    localparam logic [ST_W-1:0] S_RDA   = 5'd4;
    localparam logic [ST_W-1:0] S_RDB   = 5'd5;
    localparam logic [ST_W-1:0] S_RDC   = 5'd6;
    localparam logic [ST_W-1:0] S_MSW1  = 5'd7;
    localparam logic [ST_W-1:0] S_MSW2  = 5'd8;
    localparam logic [ST_W-1:0] S_LRD   = 5'd9;
    localparam logic [ST_W-1:0] S_LCK   = 5'd10;
    localparam logic [ST_W-1:0] S_LSW1  = 5'd11;
    localparam logic [ST_W-1:0] S_LSW2  = 5'd12;
    localparam logic [ST_W-1:0] S_FRD   = 5'd13;
    localparam logic [ST_W-1:0] S_FW1   = 5'd14;
    localparam logic [ST_W-1:0] S_FW2   = 5'd15;
    localparam logic [ST_W-1:0] S_PUSH1 = 5'd16;
    localparam logic [ST_W-1:0] S_PUSH2 = 5'd17;
    localparam logic [ST_W-1:0] S_ORD   = 5'd18;
    localparam logic [ST_W-1:0] S_OLD   = 5'd19;
    localparam logic [ST_W-1:0] S_OWT   = 5'd20;

    typedef struct packed {
        logic [ST_W-1:0] op;
        logic            in_beat;
        logic            out_beat;
    } t_cmd;

    typedef struct packed {
        logic sp_zero;
        logic j_eq_hi;
        logic le_pivot;
        logic ip_eq_j;
        logic out_valid;
        logic out_last;
    } t_stat;

endpackage

`default_nettype wire

[hdl/qsm3_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module qsm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/qsm3_ctrl.sv]
// sequencer of the quicksort block: load, partition loop, result drain
`default_nettype none

module qsm3_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_s_tvalid,
    input  wire            i_s_tlast,
    input  wire            i_m_tready,
    input  qsm3_pkg::t_stat i_stat,
    output logic           o_s_tready,
    output qsm3_pkg::t_cmd o_cmd
);

    logic [qsm3_pkg::ST_W-1:0] r_state;
    logic [qsm3_pkg::ST_W-1:0] n_state;
    logic                      w_in_beat;
    logic                      w_out_beat;

    assign o_s_tready = (r_state == qsm3_pkg::S_IDLE);
    assign w_in_beat  = o_s_tready & i_s_tvalid;
    assign w_out_beat = i_stat.out_valid & i_m_tready;

    assign o_cmd.op       = r_state;
    assign o_cmd.in_beat  = w_in_beat;
    assign o_cmd.out_beat = w_out_beat;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qsm3_pkg::S_IDLE:  if (w_in_beat && i_s_tlast) n_state = qsm3_pkg::S_INIT;
            qsm3_pkg::S_INIT:  n_state = qsm3_pkg::S_POP;
            qsm3_pkg::S_POP:   n_state = i_stat.sp_zero ? qsm3_pkg::S_ORD : qsm3_pkg::S_RANGE;
            qsm3_pkg::S_RANGE: n_state = qsm3_pkg::S_RDA;
            qsm3_pkg::S_RDA:   n_state = qsm3_pkg::S_RDB;
            qsm3_pkg::S_RDB:   n_state = qsm3_pkg::S_RDC;
            qsm3_pkg::S_RDC:   n_state = qsm3_pkg::S_MSW1;
            qsm3_pkg::S_MSW1:  n_state = qsm3_pkg::S_MSW2;
            qsm3_pkg::S_MSW2:  n_state = qsm3_pkg::S_LRD;
            qsm3_pkg::S_LRD:   n_state = i_stat.j_eq_hi ? qsm3_pkg::S_FRD : qsm3_pkg::S_LCK;
            qsm3_pkg::S_LCK: begin
                if (i_stat.le_pivot && !i_stat.ip_eq_j) n_state = qsm3_pkg::S_LSW1;
                else                                    n_state = qsm3_pkg::S_LRD;
            end
            qsm3_pkg::S_LSW1:  n_state = qsm3_pkg::S_LSW2;
            qsm3_pkg::S_LSW2:  n_state = qsm3_pkg::S_LRD;
            qsm3_pkg::S_FRD:   n_state = qsm3_pkg::S_FW1;
            qsm3_pkg::S_FW1:   n_state = qsm3_pkg::S_FW2;
            qsm3_pkg::S_FW2:   n_state = qsm3_pkg::S_PUSH1;
            qsm3_pkg::S_PUSH1: n_state = qsm3_pkg::S_PUSH2;
            qsm3_pkg::S_PUSH2: n_state = qsm3_pkg::S_POP;
            qsm3_pkg::S_ORD:   n_state = qsm3_pkg::S_OLD;
            qsm3_pkg::S_OLD:   n_state = qsm3_pkg::S_OWT;
            qsm3_pkg::S_OWT: begin
                if (w_out_beat) begin
                    n_state = i_stat.out_last ? qsm3_pkg::S_IDLE : qsm3_pkg::S_ORD;
                end
            end
            default:           n_state = qsm3_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qsm3_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[hdl/qsm3_dp.sv]
// datapath of the quicksort block: element store, range stack, pointers, counters
`default_nettype none

module qsm3_dp #(
    parameter int MAX_ELEMS  = qsm3_pkg::MAX_ELEMS_DEF,
    parameter int DATA_WIDTH = qsm3_pkg::DATA_WIDTH_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  qsm3_pkg::t_cmd             i_cmd,
    input  wire [DATA_WIDTH-1:0]       i_value,
    output qsm3_pkg::t_stat            o_stat,
    output logic [DATA_WIDTH-1:0]      o_sorted_value,
    output logic [qsm3_pkg::POS_W-1:0] o_position,
    output logic                       o_final_res,
    output logic [qsm3_pkg::CMP_W-1:0] o_comparisons,
    output logic                       o_overflow
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int CW = AW + 1;
    localparam int SW = 2 * AW;
    localparam logic [CW-1:0] CAP = CW'(MAX_ELEMS);

    logic [CW-1:0]         r_cnt;
    logic                  r_drop;
    logic [CW-1:0]         r_sp;
    logic [qsm3_pkg::CMP_W-1:0] r_cmp;
    logic [AW-1:0]         r_lo, r_hi, r_ip, r_j, r_k;
    logic [DATA_WIDTH-1:0] r_a, r_b, r_c, r_piv, r_t0, r_t1;
    logic                  r_oval, r_olast;
    logic [DATA_WIDTH-1:0] r_odata;

    logic                  mem_we, mem_re, stk_we, stk_re;
    logic [AW-1:0]         mem_waddr, mem_raddr, stk_waddr, stk_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, w_mrd;
    logic [SW-1:0]         stk_wdata, w_srd;

    logic [CW-1:0]         w_sum;
    logic [AW-1:0]         w_mid, w_med;
    logic [DATA_WIDTH-1:0] w_medv;
    logic                  w_le, w_room, w_ok1, w_ok2, w_has_room;
    logic [CW-1:0]         w_cnt_m1, w_sp_m1;

    qsm3_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_store (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_re(mem_re), .i_raddr(mem_raddr), .o_rdata(w_mrd)
    );

    // each stack entry holds lo in the low half and hi in the high half
    qsm3_ram #(.WIDTH(SW), .DEPTH(MAX_ELEMS)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(w_srd)
    );

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[AW:1];
    assign w_le     = $signed(w_mrd) <= $signed(r_piv);
    assign w_room   = r_cnt < CAP;
    assign w_has_room = r_sp < CAP;
    assign w_ok1    = w_has_room && ({1'b0, r_ip} > ({1'b0, r_lo} + CW'(1)));
    assign w_ok2    = w_has_room && (({1'b0, r_ip} + CW'(1)) < {1'b0, r_hi});
    assign w_cnt_m1 = r_cnt - CW'(1);
    assign w_sp_m1  = r_sp - CW'(1);

    // median of left, middle and right entries
    always_comb begin
        if ($signed(r_a) < $signed(r_b)) begin
            if ($signed(r_b) < $signed(r_c))      begin w_med = w_mid; w_medv = r_b; end
            else if ($signed(r_a) < $signed(r_c)) begin w_med = r_hi;  w_medv = r_c; end
            else                                  begin w_med = r_lo;  w_medv = r_a; end
        end else begin
            if ($signed(r_c) < $signed(r_b))      begin w_med = w_mid; w_medv = r_b; end
            else if ($signed(r_c) < $signed(r_a)) begin w_med = r_hi;  w_medv = r_c; end
            else                                  begin w_med = r_lo;  w_medv = r_a; end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ip;
        mem_wdata = r_piv;
        mem_re    = 1'b0;
        mem_raddr = r_ip;
        stk_we    = 1'b0;
        stk_waddr = r_sp[AW-1:0];
        stk_wdata = {r_hi, r_lo};
        stk_re    = 1'b0;
        stk_raddr = w_sp_m1[AW-1:0];
        unique case (i_cmd.op)
            qsm3_pkg::S_IDLE: begin
                mem_we    = i_cmd.in_beat & w_room;
                mem_waddr = r_cnt[AW-1:0];
                mem_wdata = i_value;
            end
            qsm3_pkg::S_INIT: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {w_cnt_m1[AW-1:0], {AW{1'b0}}};
            end
            qsm3_pkg::S_POP:   stk_re = ~o_stat.sp_zero;
            qsm3_pkg::S_RANGE: begin
                mem_re    = 1'b1;
                mem_raddr = w_srd[AW-1:0];
            end
            qsm3_pkg::S_RDA: begin
                mem_re    = 1'b1;
                mem_raddr = w_mid;
            end
            qsm3_pkg::S_RDB: begin
                mem_re    = 1'b1;
                mem_raddr = r_hi;
            end
            qsm3_pkg::S_MSW1: begin
                mem_we    = 1'b1;
                mem_waddr = w_med;
                mem_wdata = r_c;
            end
            qsm3_pkg::S_MSW2: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_piv;
            end
            qsm3_pkg::S_LRD: begin
                mem_re    = ~o_stat.j_eq_hi;
                mem_raddr = r_j;
            end
            qsm3_pkg::S_LCK:   mem_re = w_le & (r_ip != r_j);
            qsm3_pkg::S_LSW1: begin
                mem_we    = 1'b1;
                mem_wdata = r_t0;
            end
            qsm3_pkg::S_LSW2: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_t1;
            end
            qsm3_pkg::S_FRD:   mem_re = 1'b1;
            qsm3_pkg::S_FW1:   mem_we = 1'b1;
            qsm3_pkg::S_FW2: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_t0;
            end
            qsm3_pkg::S_PUSH1: begin
                stk_we    = w_ok1;
                stk_wdata = {r_ip - AW'(1), r_lo};
            end
            qsm3_pkg::S_PUSH2: begin
                stk_we    = w_ok2;
                stk_wdata = {r_hi, r_ip + AW'(1)};
            end
            qsm3_pkg::S_ORD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_sp   <= '0;
            r_cmp  <= '0;
            r_k    <= '0;
            r_oval <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                qsm3_pkg::S_IDLE: begin
                    if (i_cmd.in_beat) begin
                        if (w_room) r_cnt  <= r_cnt + CW'(1);
                        else        r_drop <= 1'b1;
                    end
                end
                qsm3_pkg::S_INIT: begin
                    r_sp  <= CW'(1);
                    r_cmp <= '0;
                    r_k   <= '0;
                end
                qsm3_pkg::S_POP: if (!o_stat.sp_zero) r_sp <= w_sp_m1;
                qsm3_pkg::S_RANGE: begin
                    r_lo <= w_srd[AW-1:0];
                    r_hi <= w_srd[SW-1:AW];
                end
                qsm3_pkg::S_RDA: r_a <= w_mrd;
                qsm3_pkg::S_RDB: r_b <= w_mrd;
                qsm3_pkg::S_RDC: r_c <= w_mrd;
                qsm3_pkg::S_MSW1: begin
                    r_piv <= w_medv;
                    r_ip  <= r_lo;
                    r_j   <= r_lo;
                end
                qsm3_pkg::S_LCK: begin
                    if (r_cmp != qsm3_pkg::CMP_MAX) r_cmp <= r_cmp + qsm3_pkg::CMP_W'(1);
                    if (w_le) begin
                        if (r_ip == r_j) begin
                            r_ip <= r_ip + AW'(1);
                            r_j  <= r_j + AW'(1);
                        end else begin
                            r_t0 <= w_mrd;
                        end
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                qsm3_pkg::S_LSW1: r_t1 <= w_mrd;
                qsm3_pkg::S_LSW2: begin
                    r_ip <= r_ip + AW'(1);
                    r_j  <= r_j + AW'(1);
                end
                qsm3_pkg::S_FW1:   r_t0 <= w_mrd;
                qsm3_pkg::S_PUSH1: if (w_ok1) r_sp <= r_sp + CW'(1);
                qsm3_pkg::S_PUSH2: if (w_ok2) r_sp <= r_sp + CW'(1);
                qsm3_pkg::S_OLD: begin
                    r_oval  <= 1'b1;
                    r_odata <= w_mrd;
                    r_olast <= ({1'b0, r_k} == w_cnt_m1);
                end
                qsm3_pkg::S_OWT: begin
                    if (i_cmd.out_beat) begin
                        r_oval <= 1'b0;
                        r_k    <= r_k + AW'(1);
                        if (r_olast) begin
                            r_cnt  <= '0;
                            r_drop <= 1'b0;
                            r_cmp  <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.sp_zero   = (r_sp == '0);
    assign o_stat.j_eq_hi   = (r_j == r_hi);
    assign o_stat.le_pivot  = w_le;
    assign o_stat.ip_eq_j   = (r_ip == r_j);
    assign o_stat.out_valid = r_oval;
    assign o_stat.out_last  = r_olast;

    assign o_sorted_value = r_odata;
    assign o_position     = qsm3_pkg::POS_W'(r_k);
    assign o_final_res    = r_olast;
    assign o_comparisons  = r_cmp;
    assign o_overflow     = r_drop;

endmodule

`default_nettype wire

[hdl/quicksort_median_of_three.sv]
// top level of the iterative median-of-three quicksort block
//
//  channel | dir | payload                                           | beat
//  s       | in  | tdata: value; tlast: last element of the set     | tvalid & tready
//  m       | out | tdata: sorted_value, position, comparisons,      | tvalid & tready
//          |     |       overflow; tlast: final result of the run    |
//
// loading takes one cycle per element, tready stays high until the last beat
// the sort then runs from one ram read port: an init step seeds the stack, each
// partition pops a range, picks the median of three as pivot, walks the range
// with swaps and pushes the subranges; draining stalls while m tready is low
// synchronous active-low reset clears counts, stack pointer and the sequencer
`default_nettype none

module quicksort_median_of_three #(
    parameter int MAX_ELEMS  = qsm3_pkg::MAX_ELEMS_DEF,
    parameter int DATA_WIDTH = qsm3_pkg::DATA_WIDTH_DEF,
    parameter int IN_W       = ((DATA_WIDTH + 7) / 8) * 8,
    parameter int OUT_W      = ((DATA_WIDTH + qsm3_pkg::POS_W + qsm3_pkg::CMP_W + 1 + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    // value (DATA_WIDTH bits) from bit 0, zero padding above
    input  wire [IN_W-1:0]   i_s_tdata,
    input  wire              i_s_tvalid,
    input  wire              i_s_tlast,
    output logic             o_s_tready,
    // sorted_value, position (6), comparisons (11), overflow (1), zero padding
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_m_tvalid,
    output logic             o_m_tlast,
    input  wire              i_m_tready
);

    localparam int PAD_W = OUT_W - (DATA_WIDTH + qsm3_pkg::POS_W + qsm3_pkg::CMP_W + 1);

    qsm3_pkg::t_cmd                w_cmd;
    qsm3_pkg::t_stat               w_stat;
    logic [DATA_WIDTH-1:0]         w_sorted_value;
    logic [qsm3_pkg::POS_W-1:0]    w_position;
    logic                          w_final_res;
    logic [qsm3_pkg::CMP_W-1:0]    w_comparisons;
    logic                          w_overflow;

    // sequencer: input acceptance, partition walk, drain
    qsm3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // element store, range stack and output register
    qsm3_dp #(
        .MAX_ELEMS  (MAX_ELEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_s_tdata[DATA_WIDTH-1:0]),
        .o_stat         (w_stat),
        .o_sorted_value (w_sorted_value),
        .o_position     (w_position),
        .o_final_res    (w_final_res),
        .o_comparisons  (w_comparisons),
        .o_overflow     (w_overflow)
    );

    // result beat packing, lowest field first
    assign o_m_tdata  = {{PAD_W{1'b0}}, w_overflow, w_comparisons, w_position, w_sorted_value};
    assign o_m_tvalid = w_stat.out_valid;
    assign o_m_tlast  = w_final_res;

endmodule

`default_nettype wire

[hdl/qsm3_checker.sv]
// port-level checker of the quicksort block and its bind
`default_nettype none
`include "quicksort_median_of_three_defines.svh"

module qsm3_checker #(
    parameter int OUT_W = 56
) (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_s_tvalid,
    input wire             i_s_tready,
    input wire             i_s_tlast,
    input wire [OUT_W-1:0] i_mst_tdata,
    input wire             i_mst_tvalid,
    input wire             i_mst_tlast,
    input wire             i_m_tready
);

    // input and result sides never open at once
    `QSM3_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, i_mst_tvalid, !i_s_tready, "ready while draining")
    // a last input beat closes the input side
    `QSM3_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, i_s_tvalid && i_s_tready && i_s_tlast, !i_s_tready && !i_mst_tvalid, "input side open after last beat")
    // final result beat ends the drain
    `QSM3_ASSERT_NEXT(a_final_ends, i_clk, i_rst_n, i_mst_tvalid && i_m_tready && i_mst_tlast, !i_mst_tvalid, "result after final beat")
    // stalled result holds
    `QSM3_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_mst_tvalid && !i_m_tready, i_mst_tvalid && $stable(i_mst_tdata) && $stable(i_mst_tlast), "stalled result changed")

endmodule

bind quicksort_median_of_three qsm3_checker #(.OUT_W(OUT_W)) u_qsm3_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_s_tvalid   (i_s_tvalid),
    .i_s_tready   (o_s_tready),
    .i_s_tlast    (i_s_tlast),
    .i_mst_tdata  (o_m_tdata),
    .i_mst_tvalid (o_m_tvalid),
    .i_mst_tlast  (o_m_tlast),
    .i_m_tready   (i_m_tready)
);

`default_nettype wire
